// ----- hdl/prt_pkg.sv -----
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and field widths for the pending request tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package prt_pkg;

  localparam int ID_W    = 32;
  localparam int STAMP_W = 48;
  localparam int CMD_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ISSUE    = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_t;

  typedef logic [ID_W-1:0]    id_t;
  typedef logic [STAMP_W-1:0] stamp_t;

endpackage

`default_nettype wire

// ----- hdl/prt_if.sv -----
// ----------------------------------------------------------------------------
// prt_in_if / prt_out_if
// Valid/ready channels carrying request commands and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface prt_in_if import prt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  id_t                lookup_id;
  stamp_t             now_ms;

  modport source (output valid, output command, output lookup_id, output now_ms,
                  input ready);
  modport sink   (input valid, input command, input lookup_id, input now_ms,
                  output ready);
endinterface

interface prt_out_if import prt_pkg::*;;
  logic   valid;
  logic   ready;
  logic   status;
  id_t    issued_id;
  stamp_t stamp_ms;
  logic   dropped_oldest;

  modport source (output valid, output status, output issued_id, output stamp_ms,
                  output dropped_oldest, input ready);
  modport sink   (input valid, input status, input issued_id, input stamp_ms,
                  input dropped_oldest, output ready);
endinterface

`default_nettype wire

// ----- hdl/prt_ram.sv -----
// ----------------------------------------------------------------------------
// prt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pending_request_tracker.sv -----
// ----------------------------------------------------------------------------
// pending_request_tracker
// Bounded queue of outstanding request ids with stored issue timestamps.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while the pending register is empty or can
// move on; its result is held in the pending register and then registered at
// the output once that is free. Queue state is updated at the accepting edge,
// and the stamp of a completed id comes from the registered read port of the
// stamp RAM in the following cycle. Ids in the queue are consecutive, so a
// completion is an offset from the oldest id. Issuing into a full queue drops
// the oldest entry and flags it. The stamp RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_request_tracker import prt_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  prt_in_if.sink     in_ch,
  prt_out_if.source  out_ch
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  typedef struct packed {
    logic status;
    id_t  issued_id;
    logic dropped;
    logic hit;
  } pend_t;

  function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] sum);
    if (sum >= DEPTH_S) begin
      return AW'(sum - DEPTH_S);
    end
    return AW'(sum);
  endfunction

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  id_t           oldest_id, oldest_id_next;
  id_t           next_id, next_id_next;

  logic          pend_valid;
  pend_t         pend, pend_next;

  logic          out_valid;
  logic          out_status;
  id_t           out_issued_id;
  stamp_t        out_stamp;
  logic          out_dropped;

  logic          in_acc, out_free;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  stamp_t        rdata;
  id_t           off;
  logic [CW-1:0] off_c;
  logic          hit;

  assign out_free    = !out_valid || out_ch.ready;
  assign in_ch.ready = !pend_valid || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign off   = in_ch.lookup_id - oldest_id;
  assign off_c = off[CW-1:0];
  assign hit   = off < ID_W'(count);

  always_comb begin
    logic          full;
    logic [AW-1:0] h1;
    logic [CW-1:0] c1;
    full           = (count == DEPTH_C);
    h1             = full ? wrap_slot(SW'(head) + SW'(1)) : head;
    c1             = full ? DEPTH_C - CW'(1) : count;
    head_next      = head;
    count_next     = count;
    oldest_id_next = oldest_id;
    next_id_next   = next_id;
    we             = 1'b0;
    waddr          = '0;
    re             = 1'b0;
    raddr          = '0;
    pend_next      = '0;
    if (in_acc) begin
      case (cmd_t'(in_ch.command))
        CMD_ISSUE: begin
          head_next    = h1;
          count_next   = c1 + CW'(1);
          next_id_next = next_id + ID_W'(1);
          if (c1 == '0) begin
            oldest_id_next = next_id;
          end else if (full) begin
            oldest_id_next = oldest_id + ID_W'(1);
          end
          we                  = 1'b1;
          waddr               = wrap_slot(SW'(h1) + SW'(c1));
          pend_next.issued_id = next_id;
          pend_next.dropped   = full;
        end
        CMD_COMPLETE: begin
          if (hit) begin
            re             = 1'b1;
            raddr          = wrap_slot(SW'(head) + SW'(off_c));
            head_next      = wrap_slot(SW'(head) + SW'(off_c) + SW'(1));
            count_next     = count - (off_c + CW'(1));
            oldest_id_next = in_ch.lookup_id + ID_W'(1);
            pend_next.hit  = 1'b1;
          end else begin
            pend_next.status = 1'b1;
          end
        end
        CMD_CLEAR: begin
          head_next  = '0;
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  prt_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_ch.now_ms),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      oldest_id <= '0;
      next_id   <= '0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      oldest_id <= oldest_id_next;
      next_id   <= next_id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_acc) begin
      pend_valid <= 1'b1;
    end else if (out_free) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend_valid) begin
      out_status    <= pend.status;
      out_issued_id <= pend.issued_id;
      out_stamp     <= pend.hit ? rdata : '0;
      out_dropped   <= pend.dropped;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_status;
  assign out_ch.issued_id      = out_issued_id;
  assign out_ch.stamp_ms       = out_stamp;
  assign out_ch.dropped_oldest = out_dropped;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count beyond queue depth");

  a_issue_nonempty: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_ch.command == CMD_ISSUE) |=> count != '0)
    else $error("queue empty after issue");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_ch.command == CMD_CLEAR) |=> (count == '0) && (head == '0))
    else $error("queue not empty after clear");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |->
      (out_issued_id == '0) && (out_stamp == '0) && !out_dropped)
    else $error("miss result carries data");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pending request tracker.
// A queue of commands is built up front. It holds a short directed run and
// then random issue bursts, hits, misses, clears, queue fills and noise. A
// clocked driver offers the commands with random gaps. A clocked monitor
// predicts each accepted item from its own copy of the tracker state and
// checks every result against the oldest prediction. The receiver stalls at
// random and holds off once for a long stretch. The sender drains twice.
// ----------------------------------------------------------------------------
module tb;
  import prt_pkg::*;

  localparam int DEPTH       = 64;
  localparam int ITEM_TARGET = 450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 180;
  localparam int HOLD_LEN    = 400;
  localparam int TAIL_ITEMS  = 50;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic             pause;
    logic [CMD_W-1:0] command;
    id_t              lookup_id;
    stamp_t           now_ms;
  } req_item_t;

  typedef struct packed {
    logic   status;
    id_t    issued_id;
    stamp_t stamp_ms;
    logic   dropped_oldest;
  } outcome_t;

  typedef struct {
    logic [DEPTH-1:0][STAMP_W-1:0] stamps;
    int unsigned head;
    int unsigned count;
    id_t         oldest;
    id_t         next;
  } tracker_t;

  logic      clk        = 1'b0;
  logic      rst        = 1'b1;
  logic      src_valid  = 1'b0;
  logic      sink_ready = 1'b0;
  req_item_t offer      = '0;

  req_item_t cmd_queue[$];
  outcome_t  due_outcomes[$];
  tracker_t  track_gen;
  tracker_t  track_chk;

  int item_total    = 0;
  int items_taken   = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int hits          = 0;
  int misses        = 0;
  int drops         = 0;
  int clears        = 0;
  int cycles        = 0;
  int send_gap      = 0;
  int recv_gap      = 0;
  int send_idle_pct = 20;
  int recv_idle_pct = 20;
  int sent_in_mode  = 0;
  int recv_in_mode  = 0;
  int hold_cnt      = 0;
  bit in_taken      = 1'b0;
  bit waiting_drain = 1'b0;
  bit quiet_tail    = 1'b0;
  bit hold_off      = 1'b0;
  bit hold_done     = 1'b0;

  prt_in_if  in_ch ();
  prt_out_if out_ch ();

  assign in_ch.valid     = src_valid;
  assign in_ch.command   = offer.command;
  assign in_ch.lookup_id = offer.lookup_id;
  assign in_ch.now_ms    = offer.now_ms;
  assign out_ch.ready    = sink_ready;

  pending_request_tracker #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic tracker_t tracker_reset();
    tracker_t t;
    t.stamps = '0;
    t.head   = 0;
    t.count  = 0;
    t.oldest = '0;
    t.next   = '0;
    return t;
  endfunction

  function automatic outcome_t tracker_step(inout tracker_t t, input req_item_t it);
    outcome_t r;
    id_t      off;
    id_t      id;
    r = '0;
    case (it.command)
      CMD_ISSUE: begin
        if (t.count >= DEPTH) begin
          t.head           = (t.head + 1) % DEPTH;
          t.count          = DEPTH - 1;
          t.oldest         = t.oldest + 1;
          r.dropped_oldest = 1'b1;
        end
        id     = t.next;
        t.next = t.next + 1;
        if (t.count == 0) t.oldest = id;
        t.stamps[(t.head + t.count) % DEPTH] = it.now_ms;
        t.count++;
        r.issued_id = id;
      end
      CMD_COMPLETE: begin
        off = it.lookup_id - t.oldest;
        if (off < t.count) begin
          r.stamp_ms = t.stamps[(t.head + off) % DEPTH];
          t.head     = (t.head + off + 1) % DEPTH;
          t.count    = t.count - (off + 1);
          t.oldest   = it.lookup_id + 1;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_CLEAR: begin
        t.count = 0;
        t.head  = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stamp_t rand_stamp();
    return stamp_t'({$urandom, $urandom});
  endfunction

  function automatic int idle_pct_pick();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 12;
      default: return 40;
    endcase
  endfunction

  task automatic add_item(input logic [CMD_W-1:0] cmd, input id_t id, input stamp_t stamp);
    req_item_t it;
    it.pause     = 1'b0;
    it.command   = cmd;
    it.lookup_id = id;
    it.now_ms    = stamp;
    void'(tracker_step(track_gen, it));
    cmd_queue.push_back(it);
    item_total++;
  endtask

  // monitor and predictor: results are checked before the new item is predicted
  always @(posedge clk) begin : monitor
    outcome_t got;
    outcome_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (out_ch.valid && sink_ready) begin
        got.status         = out_ch.status;
        got.issued_id      = out_ch.issued_id;
        got.stamp_ms       = out_ch.stamp_ms;
        got.dropped_oldest = out_ch.dropped_oldest;
        results_seen++;
        if (due_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d id %h stamp %h drop %0d",
                     got.status, got.issued_id, got.stamp_ms, got.dropped_oldest);
        end else begin
          want = due_outcomes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected status %0d id %h stamp %h drop %0d",
                       want.status, want.issued_id, want.stamp_ms, want.dropped_oldest);
              $display("          got      status %0d id %h stamp %h drop %0d",
                       got.status, got.issued_id, got.stamp_ms, got.dropped_oldest);
            end
          end
        end
      end
      if (src_valid && in_ch.ready) begin
        in_taken = 1'b1;
        want = tracker_step(track_chk, offer);
        due_outcomes.push_back(want);
        items_taken++;
        if (offer.command == CMD_COMPLETE) begin
          if (want.status) misses++;
          else hits++;
        end
        if (offer.command == CMD_CLEAR) clears++;
        if (want.dropped_oldest) drops++;
      end
    end
    quiet_tail = (item_total - items_taken) < TAIL_ITEMS;
  end

  always @(negedge clk) begin : driver
    if (rst) begin
      src_valid <= 1'b0;
    end else if (!src_valid || in_taken) begin
      if (waiting_drain) begin
        src_valid <= 1'b0;
        if (due_outcomes.size() == 0) waiting_drain = 1'b0;
      end else if (send_gap > 0) begin
        send_gap--;
        src_valid <= 1'b0;
      end else if (cmd_queue.size() == 0) begin
        src_valid <= 1'b0;
      end else if (cmd_queue[0].pause) begin
        cmd_queue.delete(0);
        waiting_drain = 1'b1;
        src_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(99) < send_idle_pct) begin
        send_gap = $urandom_range(10);
        src_valid <= 1'b0;
      end else begin
        offer <= cmd_queue.pop_front();
        src_valid <= 1'b1;
        sent_in_mode++;
        if (sent_in_mode == 40) begin
          sent_in_mode  = 0;
          send_idle_pct = idle_pct_pick();
        end
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (rst || hold_off) begin
      sink_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      sink_ready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(99) < recv_idle_pct) begin
      recv_gap = $urandom_range(10);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
      recv_in_mode++;
      if (recv_in_mode == 60) begin
        recv_in_mode  = 0;
        recv_idle_pct = idle_pct_pick();
      end
    end
  end

  // one long output stall while the sender keeps going
  always @(negedge clk) begin : long_hold
    if (!rst && !hold_done && !hold_off && items_taken >= HOLD_AT) begin
      hold_off <= 1'b1;
    end else if (hold_off) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN - 1) begin
        hold_off  <= 1'b0;
        hold_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               due_outcomes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    id_t         id;
    int unsigned span;
    int          reps;
    int          r;
    int          fill_cnt;
    bit          paused_mid;
    fill_cnt   = 0;
    paused_mid = 1'b0;
    track_gen  = tracker_reset();
    track_chk  = tracker_reset();

    add_item(CMD_COMPLETE, '0, '1);
    add_item(CMD_UNUSED, $urandom, rand_stamp());
    add_item(CMD_CLEAR, $urandom, rand_stamp());
    add_item(CMD_ISSUE, '1, '0);
    add_item(CMD_ISSUE, $urandom, '1);
    add_item(CMD_ISSUE, $urandom, 48'hAAAA_AAAA_AAAA);
    add_item(CMD_ISSUE, $urandom, 48'h5555_5555_5555);
    add_item(CMD_COMPLETE, 32'd0, '1);
    add_item(CMD_COMPLETE, 32'd0, rand_stamp());
    add_item(CMD_COMPLETE, '1, rand_stamp());
    add_item(CMD_COMPLETE, 32'd4, rand_stamp());
    add_item(CMD_ISSUE, $urandom, rand_stamp());
    add_item(CMD_ISSUE, $urandom, rand_stamp());
    add_item(CMD_COMPLETE, 32'd3, rand_stamp());
    add_item(CMD_COMPLETE, 32'd5, rand_stamp());
    add_item(CMD_ISSUE, $urandom, rand_stamp());
    add_item(CMD_CLEAR, $urandom, rand_stamp());
    add_item(CMD_COMPLETE, 32'd6, rand_stamp());
    add_item(CMD_ISSUE, $urandom, rand_stamp());
    add_item(CMD_COMPLETE, 32'd7, rand_stamp());
    cmd_queue.push_back('{pause: 1'b1, default: '0});

    while (item_total < ITEM_TARGET) begin
      if (!paused_mid && item_total >= 300) begin
        cmd_queue.push_back('{pause: 1'b1, default: '0});
        paused_mid = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 35) begin
        reps = $urandom_range(1, 6);
        repeat (reps) add_item(CMD_ISSUE, $urandom, rand_stamp());
      end else if (r < 60 && track_gen.count > 0) begin
        // mostly near the oldest entry, sometimes anywhere in the queue
        span = track_gen.count;
        if (span > 4 && $urandom_range(1) == 0) span = 4;
        add_item(CMD_COMPLETE, track_gen.oldest + $urandom_range(span - 1), rand_stamp());
      end else if (r < 72) begin
        case ($urandom_range(2))
          0:       id = track_gen.oldest - $urandom_range(1, 40);
          1:       id = track_gen.next + $urandom_range(40);
          default: id = $urandom;
        endcase
        add_item(CMD_COMPLETE, id, rand_stamp());
      end else if (r < 77) begin
        add_item(CMD_CLEAR, $urandom, rand_stamp());
      end else if (r < 81) begin
        add_item(CMD_UNUSED, $urandom, rand_stamp());
      end else if (r < 85 && fill_cnt < 2) begin
        fill_cnt++;
        while (track_gen.count < DEPTH) add_item(CMD_ISSUE, $urandom, rand_stamp());
        reps = $urandom_range(1, 8);
        repeat (reps) add_item(CMD_ISSUE, $urandom, rand_stamp());
      end else begin
        add_item(CMD_W'($urandom_range(3)), $urandom, rand_stamp());
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (items_taken < item_total) @(posedge clk);
    while (due_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d items: %0d completions hit, %0d missed, %0d oldest drops, %0d clears",
             items_taken, hits, misses, drops, clears);
    $display("%0d results checked through random stalls, one long hold-off and two drains",
             results_seen);
    if (mismatches == 0 && due_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
